/* sv/tlic_pkg.sv */
// tlic_pkg: shared types, sizes and codes for the tape-language instruction core
// no dependencies; used by tape_language_instruction_core and tb_top
package tlic_pkg;

   localparam int PROG_DEPTH = 4096;
   localparam int TAPE_CELLS = 32768;
   localparam int LOOP_DEPTH = 64;

   localparam int PA_W   = $clog2(PROG_DEPTH);
   localparam int IP_W   = $clog2(PROG_DEPTH + 1);
   localparam int TA_W   = $clog2(TAPE_CELLS);
   localparam int FILL_W = $clog2(TAPE_CELLS + 1);
   localparam int LA_W   = $clog2(LOOP_DEPTH);
   localparam int LD_W   = $clog2(LOOP_DEPTH + 1);

   localparam logic [7:0] CH_LEFT  = 8'h3C;
   localparam logic [7:0] CH_RIGHT = 8'h3E;
   localparam logic [7:0] CH_DEC   = 8'h2D;
   localparam logic [7:0] CH_INC   = 8'h2B;
   localparam logic [7:0] CH_IN    = 8'h2C;
   localparam logic [7:0] CH_OUT   = 8'h2E;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;

   typedef enum logic [1:0] {
      KIND_LOAD    = 2'd0,
      KIND_RESTART = 2'd1,
      KIND_STEP    = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_RUN     = 3'd0,
      ST_END     = 3'd1,
      ST_BOUNDS  = 3'd2,
      ST_LOOP    = 3'd3,
      ST_FULL    = 3'd4,
      ST_IGNORED = 3'd5
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] program_char;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic        out_valid;
      logic [7:0]  out_byte;
      logic        took_input;
      status_type  status;
      logic [12:0] instr_addr;
   } rsp_type;

endpackage

/* sv/tape_language_instruction_core.sv */
// tape_language_instruction_core: sequencer, registers and memories of the tape machine
// depends on tlic_pkg and tlic_ram
//
//   channel   ports                      handshake
//   request   start, busy, req_data      taken when start && !busy
//   response  rsp_strobe, rsp_data       one cycle per transaction, cannot stall
//
// load, restart, ignored and ended-step transactions: response in the next cycle.
// step: program/tape/stack read, then execute and write back.
// '[' on a zero cell starts a match search that scans the program characters
// in order and ends at the match or at the end of the program; the search
// shares the single program store read port.
// reset is synchronous; tape cells at or past the fill count read as zero, so
// neither reset nor restart needs a clearing pass.
module tape_language_instruction_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tlic_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tlic_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN} state_type;

   state_type                     state_ff, state_in;
   logic [tlic_pkg::IP_W-1:0]     ip_ff, ip_in;
   logic [tlic_pkg::IP_W-1:0]     len_ff, len_in;
   logic [tlic_pkg::TA_W-1:0]     dp_ff, dp_in;
   logic [tlic_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic [tlic_pkg::LD_W-1:0]     depth_ff, depth_in;
   logic                          halted_ff, halted_in;
   logic [tlic_pkg::IP_W-1:0]     scan_ff, scan_in;
   logic [tlic_pkg::IP_W-1:0]     nest_ff, nest_in;
   logic [7:0]                    byte_ff, byte_in;
   logic                          strobe_ff, strobe_in;
   tlic_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          prog_we;
   logic [tlic_pkg::PA_W-1:0]     prog_raddr;
   logic [7:0]                    prog_rd;
   logic                          tape_we;
   logic [7:0]                    tape_wdata;
   logic [7:0]                    tape_rd;
   logic                          stk_we;
   logic [tlic_pkg::PA_W-1:0]     stk_rd;
   logic [7:0]                    cur_cell;

   tlic_ram #(.DEPTH(tlic_pkg::PROG_DEPTH), .WIDTH(8)) u_prog (
      .clock  (clock),
      .wr_en  (prog_we),
      .wr_addr(len_ff[tlic_pkg::PA_W-1:0]),
      .wr_data(req_data.program_char),
      .rd_addr(prog_raddr),
      .rd_data(prog_rd)
   );

   tlic_ram #(.DEPTH(tlic_pkg::TAPE_CELLS), .WIDTH(8)) u_tape (
      .clock  (clock),
      .wr_en  (tape_we),
      .wr_addr(dp_ff),
      .wr_data(tape_wdata),
      .rd_addr(dp_ff),
      .rd_data(tape_rd)
   );

   tlic_ram #(.DEPTH(tlic_pkg::LOOP_DEPTH), .WIDTH(tlic_pkg::PA_W)) u_stack (
      .clock  (clock),
      .wr_en  (stk_we),
      .wr_addr(depth_ff[tlic_pkg::LA_W-1:0]),
      .wr_data(ip_ff[tlic_pkg::PA_W-1:0]),
      .rd_addr(tlic_pkg::LA_W'(depth_ff - 1'b1)),
      .rd_data(stk_rd)
   );

   // cells at or past the fill count were never written since restart
   assign cur_cell = (tlic_pkg::FILL_W'(dp_ff) < fill_ff) ? tape_rd : 8'd0;

   always_comb begin
      case (state_ff)
         S_EXEC:  prog_raddr = tlic_pkg::PA_W'(ip_ff + 1'b1);
         S_SCAN:  prog_raddr = tlic_pkg::PA_W'(scan_ff + 1'b1);
         default: prog_raddr = ip_ff[tlic_pkg::PA_W-1:0];
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      ip_in      = ip_ff;
      len_in     = len_ff;
      dp_in      = dp_ff;
      fill_in    = fill_ff;
      depth_in   = depth_ff;
      halted_in  = halted_ff;
      scan_in    = scan_ff;
      nest_in    = nest_ff;
      byte_in    = byte_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      prog_we    = 1'b0;
      tape_we    = 1'b0;
      tape_wdata = 8'd0;
      stk_we     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               strobe_in         = 1'b1;
               rsp_in            = '0;
               rsp_in.status     = tlic_pkg::ST_RUN;
               case (req_data.kind)
                  tlic_pkg::KIND_LOAD: begin
                     if (len_ff < tlic_pkg::IP_W'(tlic_pkg::PROG_DEPTH)) begin
                        prog_we = 1'b1;
                        len_in  = len_ff + 1'b1;
                     end else begin
                        rsp_in.status = tlic_pkg::ST_FULL;
                     end
                  end
                  tlic_pkg::KIND_RESTART: begin
                     ip_in     = '0;
                     dp_in     = '0;
                     fill_in   = '0;
                     depth_in  = '0;
                     halted_in = 1'b0;
                  end
                  tlic_pkg::KIND_STEP: begin
                     if (halted_ff) begin
                        rsp_in.status = tlic_pkg::ST_IGNORED;
                     end else if (ip_ff >= len_ff) begin
                        rsp_in.status = tlic_pkg::ST_END;
                     end else begin
                        strobe_in = 1'b0;
                        byte_in   = req_data.in_byte;
                        state_in  = S_EXEC;
                     end
                  end
                  default: begin
                     rsp_in.status = tlic_pkg::ST_IGNORED;
                  end
               endcase
               rsp_in.instr_addr = 13'(ip_in);
            end
         end

         S_EXEC: begin
            strobe_in     = 1'b1;
            state_in      = S_IDLE;
            rsp_in        = '0;
            rsp_in.status = tlic_pkg::ST_RUN;
            ip_in         = ip_ff + 1'b1;
            case (prog_rd)
               tlic_pkg::CH_LEFT: begin
                  if (dp_ff == '0) begin
                     halted_in     = 1'b1;
                     ip_in         = ip_ff;
                     rsp_in.status = tlic_pkg::ST_BOUNDS;
                  end else begin
                     dp_in = dp_ff - 1'b1;
                  end
               end
               tlic_pkg::CH_RIGHT: begin
                  if (dp_ff == tlic_pkg::TA_W'(tlic_pkg::TAPE_CELLS - 1)) begin
                     halted_in     = 1'b1;
                     ip_in         = ip_ff;
                     rsp_in.status = tlic_pkg::ST_BOUNDS;
                  end else begin
                     // leaving a fresh cell: make it real so the fill stays contiguous
                     tape_we = (tlic_pkg::FILL_W'(dp_ff) == fill_ff);
                     dp_in   = dp_ff + 1'b1;
                  end
               end
               tlic_pkg::CH_DEC: begin
                  tape_we    = 1'b1;
                  tape_wdata = cur_cell - 1'b1;
               end
               tlic_pkg::CH_INC: begin
                  tape_we    = 1'b1;
                  tape_wdata = cur_cell + 1'b1;
               end
               tlic_pkg::CH_IN: begin
                  tape_we           = 1'b1;
                  tape_wdata        = byte_ff;
                  rsp_in.took_input = 1'b1;
               end
               tlic_pkg::CH_OUT: begin
                  rsp_in.out_valid = 1'b1;
                  rsp_in.out_byte  = cur_cell;
               end
               tlic_pkg::CH_OPEN: begin
                  if (cur_cell != 8'd0) begin
                     if (depth_ff >= tlic_pkg::LD_W'(tlic_pkg::LOOP_DEPTH)) begin
                        halted_in     = 1'b1;
                        ip_in         = ip_ff;
                        rsp_in.status = tlic_pkg::ST_LOOP;
                     end else begin
                        stk_we   = 1'b1;
                        depth_in = depth_ff + 1'b1;
                     end
                  end else begin
                     strobe_in = 1'b0;
                     state_in  = S_SCAN;
                     ip_in     = ip_ff;
                     scan_in   = ip_ff + 1'b1;
                     nest_in   = tlic_pkg::IP_W'(1);
                  end
               end
               tlic_pkg::CH_CLOSE: begin
                  if (depth_ff == '0) begin
                     halted_in     = 1'b1;
                     ip_in         = ip_ff;
                     rsp_in.status = tlic_pkg::ST_LOOP;
                  end else if (cur_cell != 8'd0) begin
                     ip_in = tlic_pkg::IP_W'(stk_rd) + 1'b1;
                  end else begin
                     depth_in = depth_ff - 1'b1;
                  end
               end
               default: begin
               end
            endcase
            if (tape_we && (tlic_pkg::FILL_W'(dp_ff) == fill_ff)) begin
               fill_in = fill_ff + 1'b1;
            end
            rsp_in.instr_addr = 13'(ip_in);
         end

         S_SCAN: begin
            rsp_in        = '0;
            rsp_in.status = tlic_pkg::ST_RUN;
            scan_in       = scan_ff + 1'b1;
            if (scan_ff >= len_ff) begin
               ip_in         = len_ff;
               rsp_in.status = tlic_pkg::ST_END;
               strobe_in     = 1'b1;
               state_in      = S_IDLE;
            end else if (prog_rd == tlic_pkg::CH_OPEN) begin
               nest_in = nest_ff + 1'b1;
            end else if (prog_rd == tlic_pkg::CH_CLOSE) begin
               if (nest_ff == tlic_pkg::IP_W'(1)) begin
                  ip_in     = scan_ff + 1'b1;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  nest_in = nest_ff - 1'b1;
               end
            end
            rsp_in.instr_addr = 13'(ip_in);
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ip_ff     <= '0;
         len_ff    <= '0;
         dp_ff     <= '0;
         fill_ff   <= '0;
         depth_ff  <= '0;
         halted_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ip_ff     <= ip_in;
         len_ff    <= len_in;
         dp_ff     <= dp_in;
         fill_ff   <= fill_in;
         depth_ff  <= depth_in;
         halted_ff <= halted_in;
         strobe_ff <= strobe_in;
      end
      scan_ff <= scan_in;
      nest_ff <= nest_in;
      byte_ff <= byte_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // a step entering execution never overlaps a pending response
   a_no_rsp_on_exec_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> !rsp_strobe)
      else $error("response strobe while a step starts");

   a_one_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.out_valid && rsp_data.took_input))
      else $error("step both emitted and consumed a byte");

   a_fill_covers_pointer: assert property (@(posedge clock) disable iff (reset)
      tlic_pkg::FILL_W'(dp_ff) <= fill_ff)
      else $error("data pointer past tape fill count");

   a_halt_status: assert property (@(posedge clock) disable iff (reset)
      $rose(halted_ff) |-> (rsp_strobe && (rsp_data.status == tlic_pkg::ST_BOUNDS
                                          || rsp_data.status == tlic_pkg::ST_LOOP)))
      else $error("halt without error response");

endmodule

/* sv/tlic_ram.sv */
// tlic_ram: generic single-write, single-read ram with registered read data
// no dependencies
module tlic_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for tape_language_instruction_core
// depends on tlic_pkg and the core; drives command transactions, checks responses
// against a behavioral machine model with a table-driven directed phase then random programs
module tb_top;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   tlic_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   tlic_pkg::rsp_type rsp_data;

   tape_language_instruction_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // machine model state
   logic [7:0]  prog_mem [tlic_pkg::PROG_DEPTH];
   int unsigned prog_len;
   int unsigned ip;
   logic [7:0]  tape_mem [tlic_pkg::TAPE_CELLS];
   int unsigned dp;
   int unsigned bracket_stack [tlic_pkg::LOOP_DEPTH];
   int unsigned nest_depth;
   bit          stopped;

   tlic_pkg::rsp_type expected_q[$];
   int unsigned mismatches = 0;
   int unsigned rsp_count = 0;
   bit          quiet = 0;

   function automatic void machine_clear();
      ip = 0; dp = 0; nest_depth = 0; stopped = 0;
      foreach (tape_mem[i]) tape_mem[i] = 8'h00;
   endfunction

   function automatic tlic_pkg::status_type run_char(input logic [7:0] ib,
                                                     inout tlic_pkg::rsp_type r);
      int unsigned next_ip, p, nest;
      logic [7:0] c;
      logic [7:0] cur_cell;
      bit found;
      next_ip = ip;
      c = prog_mem[ip];
      cur_cell = tape_mem[dp];
      case (c)
         tlic_pkg::CH_LEFT: begin
            if (dp == 0) begin stopped = 1; return tlic_pkg::ST_BOUNDS; end
            dp--;
         end
         tlic_pkg::CH_RIGHT: begin
            if (dp + 1 >= tlic_pkg::TAPE_CELLS) begin
               stopped = 1; return tlic_pkg::ST_BOUNDS;
            end
            dp++;
         end
         tlic_pkg::CH_DEC: tape_mem[dp] = cur_cell - 8'd1;
         tlic_pkg::CH_INC: tape_mem[dp] = cur_cell + 8'd1;
         tlic_pkg::CH_IN: begin tape_mem[dp] = ib; r.took_input = 1'b1; end
         tlic_pkg::CH_OUT: begin r.out_valid = 1'b1; r.out_byte = cur_cell; end
         tlic_pkg::CH_OPEN: begin
            if (cur_cell != 0) begin
               if (nest_depth >= tlic_pkg::LOOP_DEPTH) begin
                  stopped = 1; return tlic_pkg::ST_LOOP;
               end
               bracket_stack[nest_depth] = ip;
               nest_depth++;
            end else begin
               nest = 0; p = ip; found = 0;
               while (p < prog_len) begin
                  if (prog_mem[p] == tlic_pkg::CH_OPEN) nest++;
                  else if (prog_mem[p] == tlic_pkg::CH_CLOSE) begin
                     nest--;
                     if (nest == 0) begin found = 1; break; end
                  end
                  p++;
               end
               if (!found) begin ip = prog_len; return tlic_pkg::ST_END; end
               next_ip = p;
            end
         end
         tlic_pkg::CH_CLOSE: begin
            if (nest_depth == 0) begin stopped = 1; return tlic_pkg::ST_LOOP; end
            if (cur_cell != 0) next_ip = bracket_stack[nest_depth-1];
            else nest_depth--;
         end
         default: ;
      endcase
      ip = next_ip + 1;
      return tlic_pkg::ST_RUN;
   endfunction

   function automatic tlic_pkg::rsp_type machine_predict(input tlic_pkg::req_type q);
      tlic_pkg::rsp_type r;
      r = '0;
      r.status = tlic_pkg::ST_RUN;
      case (q.kind)
         tlic_pkg::KIND_LOAD: begin
            if (prog_len < tlic_pkg::PROG_DEPTH) begin
               prog_mem[prog_len] = q.program_char;
               prog_len++;
            end else r.status = tlic_pkg::ST_FULL;
         end
         tlic_pkg::KIND_RESTART: machine_clear();
         tlic_pkg::KIND_STEP: begin
            if (stopped) r.status = tlic_pkg::ST_IGNORED;
            else if (ip >= prog_len) r.status = tlic_pkg::ST_END;
            else r.status = run_char(q.in_byte, r);
         end
         default: r.status = tlic_pkg::ST_IGNORED;
      endcase
      r.instr_addr = ip[12:0];
      return r;
   endfunction

   // response checking
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rsp_count++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_data);
         end else begin
            tlic_pkg::rsp_type e;
            e = expected_q.pop_front();
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch #%0d: expected %p, got %p", rsp_count, e, rsp_data);
            end
         end
      end
   end

   // one transaction; optional hand-typed expectation; start stays high until
   // the next send or drain decides otherwise
   task automatic send(input tlic_pkg::req_type q, input bit has_exp = 0,
                       input tlic_pkg::rsp_type ex = '0);
      tlic_pkg::rsp_type p;
      if (!quiet) begin
         while ($urandom_range(0, 99) < 26) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = machine_predict(q);
      if (has_exp && p !== ex) begin
         mismatches++;
         if (mismatches <= 10) $display("model disagrees with table: %p vs %p", p, ex);
      end
      expected_q = {expected_q, p};
   endtask

   function automatic tlic_pkg::req_type mk(input tlic_pkg::kind_type k,
                                            input logic [7:0] pc, input logic [7:0] ib);
      tlic_pkg::req_type q;
      q.kind = k; q.program_char = pc; q.in_byte = ib;
      return q;
   endfunction

   task automatic drain();
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic load_text(input string s);
      for (int i = 0; i < s.len(); i++) send(mk(tlic_pkg::KIND_LOAD, s[i], 8'h00));
   endtask

   // restart, then step past both input-gated trap blocks with zero input
   task automatic skip_traps();
      send(mk(tlic_pkg::KIND_RESTART, 8'h00, 8'h00));
      repeat (5) send(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h00));
   endtask

   typedef struct {
      tlic_pkg::req_type q;
      bit                has_exp;
      tlic_pkg::rsp_type ex;
   } row_type;

   function automatic tlic_pkg::rsp_type rs(input tlic_pkg::status_type st, input int a);
      tlic_pkg::rsp_type r;
      r = '0; r.status = st; r.instr_addr = a[12:0];
      return r;
   endfunction

   // random program character: mostly instruction characters, some arbitrary bytes, balanced-ish brackets
   function automatic logic [7:0] rand_char();
      int k;
      k = $urandom_range(0, 19);
      case (k)
         0, 1, 2: return tlic_pkg::CH_INC;
         3, 4: return tlic_pkg::CH_DEC;
         5, 6: return tlic_pkg::CH_RIGHT;
         7: return tlic_pkg::CH_LEFT;
         8, 9: return tlic_pkg::CH_IN;
         10, 11: return tlic_pkg::CH_OUT;
         12, 13: return tlic_pkg::CH_OPEN;
         14, 15: return tlic_pkg::CH_CLOSE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   row_type rows[$];
   int items;

   function automatic void add_row(input tlic_pkg::req_type q, input bit has_exp,
                                   input tlic_pkg::rsp_type ex);
      row_type r;
      r.q = q; r.has_exp = has_exp; r.ex = ex;
      rows = {rows, r};
   endfunction

   initial begin
      prog_len = 0;
      machine_clear();

      // step before any load: ended; unknown kind ignored
      add_row(mk(tlic_pkg::KIND_STEP, 8'h00, 8'hFF), 1, rs(tlic_pkg::ST_END, 0));
      add_row(mk(tlic_pkg::KIND_NONE, 8'hFF, 8'hFF), 1, rs(tlic_pkg::ST_IGNORED, 0));
      // gated trap ",[<]" then '.': left move at cell zero only when input is nonzero
      add_row(mk(tlic_pkg::KIND_LOAD, tlic_pkg::CH_IN, 8'h00), 1, rs(tlic_pkg::ST_RUN, 0));
      add_row(mk(tlic_pkg::KIND_LOAD, tlic_pkg::CH_OPEN, 8'h00), 0, '0);
      add_row(mk(tlic_pkg::KIND_LOAD, tlic_pkg::CH_LEFT, 8'h00), 0, '0);
      add_row(mk(tlic_pkg::KIND_LOAD, tlic_pkg::CH_CLOSE, 8'h00), 0, '0);
      add_row(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h07), 0, '0);
      add_row(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h00), 1, rs(tlic_pkg::ST_RUN, 2));
      add_row(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h00), 1, rs(tlic_pkg::ST_BOUNDS, 2));
      add_row(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h00), 1, rs(tlic_pkg::ST_IGNORED, 2));
      add_row(mk(tlic_pkg::KIND_LOAD, tlic_pkg::CH_OUT, 8'h00), 1, rs(tlic_pkg::ST_RUN, 2));
      add_row(mk(tlic_pkg::KIND_RESTART, 8'hFF, 8'hFF), 1, rs(tlic_pkg::ST_RUN, 0));
      add_row(mk(tlic_pkg::KIND_STEP, 8'hFF, 8'h00), 0, '0);
      add_row(mk(tlic_pkg::KIND_STEP, 8'h00, 8'hFF), 1, rs(tlic_pkg::ST_RUN, 4));
      add_row(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h00), 0, '0);
      add_row(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h00), 1, rs(tlic_pkg::ST_END, 5));
      add_row(mk(tlic_pkg::KIND_RESTART, 8'h00, 8'h00), 1, rs(tlic_pkg::ST_RUN, 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send(rows[i].q, rows[i].has_exp, rows[i].ex);
      drain();

      // gated loop stack overflow: 65 nested opens on a nonzero cell
      send(mk(tlic_pkg::KIND_LOAD, tlic_pkg::CH_IN, 8'h00));
      repeat (65) send(mk(tlic_pkg::KIND_LOAD, tlic_pkg::CH_OPEN, 8'h00));
      repeat (65) send(mk(tlic_pkg::KIND_LOAD, tlic_pkg::CH_CLOSE, 8'h00));
      send(mk(tlic_pkg::KIND_RESTART, 8'h00, 8'h00));
      repeat (3) send(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h00));
      send(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h01));
      repeat (64) send(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h00));
      send(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h00), 1, rs(tlic_pkg::ST_LOOP, 70));
      send(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h00), 1, rs(tlic_pkg::ST_IGNORED, 70));
      // both gates closed: long forward scans, then the end of the store
      skip_traps();
      send(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h00), 1, rs(tlic_pkg::ST_END, 136));
      drain();

      // program with in/out, forward skip and loop
      load_text(",.[-].[>+<-]>.>++[<]");
      skip_traps();
      for (int i = 0; i < 40; i++) send(mk(tlic_pkg::KIND_STEP, 8'h00, 8'h03));
      drain();

      // random phase: fresh programs appended, restart, run
      items = 0;
      while (items < 700) begin
         int n;
         int steps;
         n = $urandom_range(4, 30);
         steps = $urandom_range(10, 60);
         quiet = (items > 300 && items < 450);
         for (int i = 0; i < n; i++) send(mk(tlic_pkg::KIND_LOAD, rand_char(), 8'h00));
         skip_traps();
         for (int i = 0; i < steps; i++) begin
            if ($urandom_range(0, 49) == 0)
               send(mk(tlic_pkg::KIND_NONE, 8'($urandom), 8'($urandom)));
            else
               send(mk(tlic_pkg::KIND_STEP, 8'($urandom), 8'($urandom)));
         end
         items += n + 6 + steps;
         if ($urandom_range(0, 9) == 0) drain();
      end
      quiet = 0;
      drain();

      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* filelist.f */
sv/tlic_pkg.sv
sv/tlic_ram.sv
sv/tape_language_instruction_core.sv
tb/tb_top.sv
